// ===== rtl/ttw_pkg.sv =====
// ----------------------------------------------------------------------------
// Text-mode teletype writer package
// Shared types, codes and constants of the text-mode teletype writer.
// ----------------------------------------------------------------------------
`default_nettype none

package ttw_pkg;

  localparam int COLUMNS_DEF    = 80;
  localparam int ROWS_DEF       = 25;
  localparam int CELL_WIDTH     = 16;
  localparam int CELL_COUNT_DEF = COLUMNS_DEF * ROWS_DEF;
  localparam int POS_OUT_W      = 11;
  localparam int CFG_IDX_W      = 1;

  localparam logic [7:0]            BLANK_CHAR   = 8'h20;
  localparam logic [7:0]            NEWLINE_CHAR = 8'h0A;
  localparam logic [7:0]            BYTE_MASK    = 8'hFF;
  localparam logic [CELL_WIDTH-1:0] RESET_CELL   = {8'h00, BLANK_CHAR};

  localparam logic [7:0] TELETYPE_ATTR_RESET = 8'd10;
  localparam logic [7:0] BLANK_ATTR_RESET    = 8'd0;

  localparam logic [CFG_IDX_W-1:0] CFG_TELETYPE_ATTR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLANK_ATTR    = 1'd1;

  typedef enum logic [1:0] {
    OP_TELETYPE = 2'd0,
    OP_PUT      = 2'd1,
    OP_CLEAR    = 2'd2,
    OP_READ     = 2'd3
  } op_t;

  typedef struct packed {
    op_t        operation;
    logic [7:0] char_code;
    logic [7:0] column;
    logic [7:0] row;
    logic [7:0] attribute;
  } in_item_t;

  typedef struct packed {
    logic [POS_OUT_W-1:0]  cursor_position;
    logic [CELL_WIDTH-1:0] cell_value;
  } out_item_t;

  typedef struct packed {
    logic [7:0] teletype_attribute;
    logic [7:0] blank_attribute;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/ttw_ram.sv =====
// ----------------------------------------------------------------------------
// Text-mode teletype writer RAM
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ttw_ram
  import ttw_pkg::*;
#(
  parameter int WIDTH = CELL_WIDTH,
  parameter int DEPTH = CELL_COUNT_DEF,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/ttw_addr.sv =====
// ----------------------------------------------------------------------------
// Text-mode teletype writer address unit
// Shared multiply-add that turns a row and column into a linear position.
// ----------------------------------------------------------------------------
`default_nettype none

module ttw_addr
  import ttw_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROW_W   = 5,
  parameter int COL_W   = 7,
  parameter int POS_W   = 11
) (
  input  wire logic [ROW_W-1:0] row,
  input  wire logic [COL_W-1:0] col,
  output logic      [POS_W-1:0] pos
);

  assign pos = POS_W'(row) * POS_W'(COLUMNS) + POS_W'(col);

endmodule

`default_nettype wire

// ===== rtl/ttw_seq.sv =====
// ----------------------------------------------------------------------------
// Text-mode teletype writer sequencer
// Runs each transaction through the shared address unit and the screen RAM,
// including the reset clearing pass, scroll copy, row blanking and clear.
// ----------------------------------------------------------------------------
`default_nettype none

module ttw_seq
  import ttw_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF,
  localparam int CELL_COUNT = COLUMNS * ROWS,
  localparam int ADDR_W     = $clog2(CELL_COUNT)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_data,
  input  wire cfg_t                  cfg,
  output logic                       ram_we,
  output logic      [ADDR_W-1:0]     ram_waddr,
  output logic      [CELL_WIDTH-1:0] ram_wdata,
  output logic      [ADDR_W-1:0]     ram_raddr,
  input  wire logic [CELL_WIDTH-1:0] ram_rdata
);

  localparam int POS_W      = $clog2(CELL_COUNT + 1);
  localparam int COL_W      = $clog2(COLUMNS + 1);
  localparam int ROW_W      = $clog2(ROWS);
  localparam int COPY_CELLS = (ROWS - 1) * COLUMNS;

  typedef enum logic [6:0] {
    S_INIT   = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_EXEC   = 7'b0000100,
    S_SCROLL = 7'b0001000,
    S_BLANK  = 7'b0010000,
    S_READ   = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t                  state;
  logic [ADDR_W-1:0]       idx;
  logic                    pend;
  logic [ADDR_W-1:0]       pend_addr;
  logic [COL_W-1:0]        cur_col;
  logic [ROW_W-1:0]        cur_row;
  logic                    work_done;
  in_item_t                item;
  logic [CELL_WIDTH-1:0]   read_value;

  logic                    in_grid;
  logic                    wrap;
  logic                    last_row;
  logic                    newline;
  logic                    use_cursor;
  logic [ROW_W-1:0]        au_row;
  logic [COL_W-1:0]        au_col;
  logic [POS_W-1:0]        pos;
  logic [ADDR_W-1:0]       cell_addr;
  logic [CELL_WIDTH-1:0]   blank_cell;

  assign in_grid = ({1'b0, item.column} < 9'(COLUMNS)) && ({1'b0, item.row} < 9'(ROWS));
  assign wrap       = cur_col == COL_W'(COLUMNS);
  assign last_row   = cur_row == ROW_W'(ROWS - 1);
  assign newline    = item.char_code == NEWLINE_CHAR;
  assign use_cursor = (state == S_DONE) || (item.operation == OP_TELETYPE);
  assign au_row     = use_cursor ? cur_row : item.row[ROW_W-1:0];
  assign au_col     = use_cursor ? cur_col : item.column[COL_W-1:0];
  assign cell_addr  = pos[ADDR_W-1:0];
  assign blank_cell = {cfg.blank_attribute & BYTE_MASK, BLANK_CHAR};
  assign in_stall   = state != S_IDLE;

  ttw_addr #(
    .COLUMNS (COLUMNS),
    .ROW_W   (ROW_W),
    .COL_W   (COL_W),
    .POS_W   (POS_W)
  ) u_addr (
    .row (au_row),
    .col (au_col),
    .pos (pos)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cell_addr;
    ram_wdata = {cfg.teletype_attribute, item.char_code};
    ram_raddr = cell_addr;
    case (state)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = idx;
        ram_wdata = RESET_CELL;
      end
      S_BLANK: begin
        ram_we    = 1'b1;
        ram_waddr = idx;
        ram_wdata = blank_cell;
      end
      S_SCROLL: begin
        ram_raddr = idx + ADDR_W'(COLUMNS);
        ram_we    = pend;
        ram_waddr = pend_addr;
        ram_wdata = ram_rdata;
      end
      S_EXEC: begin
        case (item.operation)
          OP_TELETYPE: ram_we = !work_done && !wrap && !newline;
          OP_PUT: begin
            ram_we    = !work_done && in_grid;
            ram_wdata = {item.attribute, item.char_code};
          end
          default: ram_we = 1'b0;
        endcase
      end
      default: ram_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      idx       <= '0;
      pend      <= 1'b0;
      cur_col   <= '0;
      cur_row   <= '0;
      work_done <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_INIT: begin
          if (idx == ADDR_W'(CELL_COUNT - 1)) begin
            idx   <= '0;
            state <= S_IDLE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            item       <= in_data;
            work_done  <= 1'b0;
            read_value <= '0;
            state      <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (work_done) begin
            state <= S_DONE;
          end else begin
            case (item.operation)
              OP_TELETYPE: begin
                if (wrap || newline) begin
                  cur_col   <= '0;
                  work_done <= !wrap;
                  if (last_row) begin
                    idx   <= '0;
                    pend  <= 1'b0;
                    state <= S_SCROLL;
                  end else begin
                    cur_row <= cur_row + 1'b1;
                  end
                end else begin
                  cur_col <= cur_col + 1'b1;
                  state   <= S_DONE;
                end
              end
              OP_PUT: state <= S_DONE;
              OP_CLEAR: begin
                cur_col   <= '0;
                cur_row   <= '0;
                idx       <= '0;
                work_done <= 1'b1;
                state     <= S_BLANK;
              end
              default: state <= in_grid ? S_READ : S_DONE;
            endcase
          end
        end
        S_SCROLL: begin
          if (idx != ADDR_W'(COPY_CELLS)) begin
            pend      <= 1'b1;
            pend_addr <= idx;
            idx       <= idx + 1'b1;
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              state <= S_BLANK;
            end
          end
        end
        S_BLANK: begin
          if (idx == ADDR_W'(CELL_COUNT - 1)) begin
            state <= S_EXEC;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_READ: begin
          read_value <= ram_rdata;
          state      <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid                <= 1'b1;
            out_data.cursor_position <= POS_OUT_W'(pos);
            out_data.cell_value      <= read_value;
            state                    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/text_mode_teletype_writer_core.sv =====
// ----------------------------------------------------------------------------
// Text-mode teletype writer core
// Screen engine with a grid of character cells and a cursor. Each input
// transaction teletypes a character, puts a cell, clears the screen or reads a
// cell, and yields one result transaction with the linear cursor position and,
// for a read, the cell value. Input and output use valid and stall; a
// transaction moves on a clock edge with valid high and stall low. The
// configuration channel uses valid and ready and is always ready.
// A plain character, a put or an out-of-range read passes through the execute
// and done states after acceptance; an in-range read adds a RAM read state, and
// each line feed and each wrap adds another execute step. Input stall drops on
// the edge that registers the result, so a transaction is accepted only after
// the previous one has finished. A line feed or wrap on the last row scrolls
// the screen one cell per cycle, and a teletype transaction can scroll twice.
// Clear writes all ROWS * COLUMNS cells, one per cycle. After reset the core
// clears all ROWS * COLUMNS cells of the RAM with input stall high. A finished
// result waits in the output register while the receiver stalls, and the next
// transaction is accepted meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module text_mode_teletype_writer_core
  import ttw_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_item_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_item_t                 out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data
);

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);

  cfg_t                  cfg;
  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [CELL_WIDTH-1:0] ram_wdata;
  logic [ADDR_W-1:0]     ram_raddr;
  logic [CELL_WIDTH-1:0] ram_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.teletype_attribute <= TELETYPE_ATTR_RESET;
      cfg.blank_attribute    <= BLANK_ATTR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TELETYPE_ATTR: cfg.teletype_attribute <= cfg_data;
        CFG_BLANK_ATTR:    cfg.blank_attribute    <= cfg_data;
        default:           cfg                    <= cfg;
      endcase
    end
  end

  ttw_seq #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg       (cfg),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  ttw_ram #(
    .WIDTH (CELL_WIDTH),
    .DEPTH (CELL_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

// ===== rtl/ttw_checker.sv =====
// ----------------------------------------------------------------------------
// Text-mode teletype writer checker
// Port-level assertions on the core, attached to it by a bind statement.
// ----------------------------------------------------------------------------
`default_nettype none

module ttw_checker
  import ttw_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data
);

  localparam int CELL_COUNT = COLUMNS * ROWS;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("Stalled result transaction changed or was dropped.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("Core accepted a transaction while the previous one was in work.");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (CELL_COUNT > 2047) ||
                  (out_data.cursor_position <= POS_OUT_W'(CELL_COUNT)))
    else $error("Cursor position lies beyond the screen.");

  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("Result transaction appeared without a transaction in work.");

endmodule

bind text_mode_teletype_writer_core ttw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_ttw_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

// ===== bench/tb_text_mode_teletype_writer_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the text-mode teletype writer core
// Drives teletype, put, clear and read transactions into the core while
// the sender and the receiver stall at random. A screen model in the bench
// predicts the cursor position and cell value of every result, including
// line wraps, scrolling and clears. It checks each result in order, field by
// field, under several attribute register settings.
// ----------------------------------------------------------------------------

module tb_text_mode_teletype_writer_core;
  import ttw_pkg::*;

  localparam int COLS        = COLUMNS_DEF;
  localparam int LINES       = ROWS_DEF;
  localparam int CELL_TOTAL  = CELL_COUNT_DEF;
  localparam int QUIET_LIMIT = 12000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data = '0;

  in_item_t        queued_ops[$];
  out_item_t       screen_replies[$];
  out_item_t       oldest_reply;
  logic [CELL_WIDTH-1:0] screen_model [CELL_TOTAL];
  int unsigned     cur_col;
  int unsigned     cur_row;
  logic [7:0]      tty_attr;
  logic [7:0]      blank_attr;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int outstanding_ops = 0;
  int total_queued = 0;
  int mismatch_count = 0;
  int results_checked = 0;
  int scroll_count = 0;
  int wrap_count = 0;
  int clear_count = 0;
  int read_count = 0;
  int quiet_cycles = 0;

  always #2 clk = ~clk;

  text_mode_teletype_writer_core uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  task automatic reset_screen_model();
    int i;
    for (i = 0; i < CELL_TOTAL; i++) screen_model[i] = RESET_CELL;
    cur_col = 0;
    cur_row = 0;
    tty_attr = TELETYPE_ATTR_RESET;
    blank_attr = BLANK_ATTR_RESET;
  endtask

  task automatic scroll_if_past_bottom();
    int i;
    if (cur_row >= LINES) begin
      for (i = 0; i < (LINES - 1) * COLS; i++) screen_model[i] = screen_model[i + COLS];
      for (i = (LINES - 1) * COLS; i < CELL_TOTAL; i++) screen_model[i] = {blank_attr, BLANK_CHAR};
      cur_row = LINES - 1;
      scroll_count++;
    end
  endtask

  task automatic line_feed();
    cur_col = 0;
    cur_row++;
    scroll_if_past_bottom();
  endtask

  task automatic predict_screen_op(input in_item_t op_item);
    out_item_t reply;
    logic      in_bounds;
    int        i;
    in_bounds = op_item.column < COLS && op_item.row < LINES;
    reply.cell_value = '0;
    case (op_item.operation)
      OP_TELETYPE: begin
        scroll_if_past_bottom();
        if (cur_col >= COLS) begin
          line_feed();
          wrap_count++;
        end
        if (op_item.char_code == NEWLINE_CHAR) begin
          line_feed();
        end else begin
          screen_model[cur_row * COLS + cur_col] = {tty_attr, op_item.char_code};
          cur_col++;
        end
      end
      OP_PUT: begin
        if (in_bounds)
          screen_model[op_item.row * COLS + op_item.column] = {op_item.attribute, op_item.char_code};
      end
      OP_CLEAR: begin
        for (i = 0; i < CELL_TOTAL; i++) screen_model[i] = {blank_attr, BLANK_CHAR};
        cur_col = 0;
        cur_row = 0;
        clear_count++;
      end
      OP_READ: begin
        if (in_bounds) reply.cell_value = screen_model[op_item.row * COLS + op_item.column];
        read_count++;
      end
    endcase
    reply.cursor_position = POS_OUT_W'(cur_row * COLS + cur_col);
    screen_replies.push_back(reply);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_screen_op(in_data);
      if (!in_valid || !in_stall) begin
        if (queued_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= queued_ops.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (screen_replies.size() == 0) begin
          $display("%0t: unexpected result, got position %0d cell %h",
                   $time, out_data.cursor_position, out_data.cell_value);
          mismatch_count++;
        end else begin
          oldest_reply = screen_replies.pop_front();
          if (out_data.cursor_position !== oldest_reply.cursor_position) begin
            $display("%0t: cursor_position mismatch, expected %0d, got %0d",
                     $time, oldest_reply.cursor_position, out_data.cursor_position);
            mismatch_count++;
          end
          if (out_data.cell_value !== oldest_reply.cell_value) begin
            $display("%0t: cell_value mismatch, expected %h, got %h",
                     $time, oldest_reply.cell_value, out_data.cell_value);
            mismatch_count++;
          end
          results_checked++;
          outstanding_ops--;
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic void queue_op(input op_t op, input logic [7:0] ch, input logic [7:0] col,
                                   input logic [7:0] row, input logic [7:0] attr);
    in_item_t op_item;
    op_item.operation = op;
    op_item.char_code = ch;
    op_item.column = col;
    op_item.row = row;
    op_item.attribute = attr;
    queued_ops.push_back(op_item);
    outstanding_ops++;
    total_queued++;
  endfunction

  function automatic logic [7:0] pick_text_byte();
    if ($urandom_range(99) < 85) return 8'($urandom_range(126, 32));
    return 8'($urandom_range(255));
  endfunction

  function automatic void queue_char(input logic [7:0] ch);
    queue_op(OP_TELETYPE, ch, 8'($urandom_range(255)), 8'($urandom_range(255)),
             8'($urandom_range(255)));
  endfunction

  // Returns {column, row}; the rest land outside the grid on one or both axes.
  function automatic logic [15:0] pick_cell(input int in_range_pct);
    logic [7:0] c;
    logic [7:0] r;
    if ($urandom_range(99) < in_range_pct) begin
      c = 8'($urandom_range(COLS - 1));
      r = 8'($urandom_range(LINES - 1));
    end else begin
      case ($urandom_range(2))
        0: begin
          c = 8'($urandom_range(255, COLS));
          r = 8'($urandom_range(255));
        end
        1: begin
          c = 8'($urandom_range(255));
          r = 8'($urandom_range(255, LINES));
        end
        default: begin
          c = 8'($urandom_range(255, COLS));
          r = 8'($urandom_range(255, LINES));
        end
      endcase
    end
    return {c, r};
  endfunction

  // A full line leaves a wrap pending; the following byte takes it first.
  function automatic void queue_full_line();
    int i;
    queue_char(NEWLINE_CHAR);
    for (i = 0; i < COLS; i++) queue_char(pick_text_byte());
    if ($urandom_range(1) == 0) queue_char(NEWLINE_CHAR);
    else queue_char(pick_text_byte());
  endfunction

  function automatic void queue_directed_ops();
    queue_op(OP_TELETYPE, 8'h41, 8'h00, 8'h00, 8'h00);
    queue_op(OP_TELETYPE, 8'h00, 8'hFF, 8'hFF, 8'hFF);
    queue_op(OP_TELETYPE, 8'hFF, 8'h00, 8'h00, 8'h00);
    queue_op(OP_TELETYPE, NEWLINE_CHAR, 8'h00, 8'h00, 8'h00);
    queue_op(OP_PUT, 8'hFF, 8'd0, 8'd0, 8'hFF);
    queue_op(OP_PUT, 8'h00, 8'(COLS - 1), 8'(LINES - 1), 8'h00);
    queue_op(OP_PUT, 8'h5A, 8'(COLS), 8'd0, 8'h77);
    queue_op(OP_PUT, 8'h5A, 8'd0, 8'(LINES), 8'h77);
    queue_op(OP_PUT, 8'h5A, 8'hFF, 8'hFF, 8'h77);
    queue_op(OP_READ, 8'h00, 8'd0, 8'd0, 8'h00);
    queue_op(OP_READ, 8'hFF, 8'd1, 8'd0, 8'hFF);
    queue_op(OP_READ, 8'h00, 8'd2, 8'd0, 8'h00);
    queue_op(OP_READ, 8'h00, 8'(COLS - 1), 8'(LINES - 1), 8'h00);
    queue_op(OP_READ, 8'h00, 8'(COLS), 8'(LINES - 1), 8'h00);
    queue_op(OP_READ, 8'h00, 8'(COLS - 1), 8'(LINES), 8'h00);
    queue_op(OP_READ, 8'h00, 8'hFF, 8'hFF, 8'h00);
    queue_op(OP_READ, 8'h00, 8'd5, 8'd3, 8'h00);
    queue_op(OP_CLEAR, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    queue_op(OP_READ, 8'h00, 8'(COLS - 1), 8'(LINES - 1), 8'h00);
    queue_op(OP_READ, 8'h00, 8'd0, 8'd0, 8'h00);
    queue_op(OP_TELETYPE, NEWLINE_CHAR, 8'h00, 8'h00, 8'h00);
    queue_op(OP_TELETYPE, 8'h7E, 8'h00, 8'h00, 8'h00);
  endfunction

  function automatic void queue_random_phase(input int target);
    int start;
    int n;
    int i;
    int r;
    logic [15:0] spot;
    start = total_queued;
    queue_full_line();
    while (total_queued - start < target) begin
      r = $urandom_range(99);
      if (r < 40) begin
        n = $urandom_range(12, 1);
        for (i = 0; i < n; i++) queue_char(pick_text_byte());
        if ($urandom_range(99) < 40) queue_char(NEWLINE_CHAR);
      end else if (r < 41) begin
        queue_full_line();
      end else if (r < 62) begin
        n = $urandom_range(4, 1);
        for (i = 0; i < n; i++) begin
          spot = pick_cell(80);
          queue_op(OP_PUT, 8'($urandom_range(255)), spot[15:8], spot[7:0],
                   8'($urandom_range(255)));
          if ($urandom_range(1) == 0)
            queue_op(OP_READ, 8'($urandom_range(255)), spot[15:8], spot[7:0],
                     8'($urandom_range(255)));
        end
      end else if (r < 84) begin
        n = $urandom_range(4, 1);
        for (i = 0; i < n; i++) begin
          spot = pick_cell(85);
          queue_op(OP_READ, 8'($urandom_range(255)), spot[15:8], spot[7:0],
                   8'($urandom_range(255)));
        end
      end else if (r < 86) begin
        queue_op(OP_CLEAR, 8'($urandom_range(255)), 8'($urandom_range(255)),
                 8'($urandom_range(255)), 8'($urandom_range(255)));
      end else if (r < 90) begin
        n = $urandom_range(6, 1);
        for (i = 0; i < n; i++) queue_char(NEWLINE_CHAR);
      end else begin
        queue_op(op_t'($urandom_range(3)), 8'($urandom_range(255)), 8'($urandom_range(255)),
                 8'($urandom_range(255)), 8'($urandom_range(255)));
      end
    end
  endfunction

  task automatic wait_for_quiet();
    while (outstanding_ops != 0) @(posedge clk);
  endtask

  task automatic set_attribute_register(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_TELETYPE_ATTR) tty_attr = value;
    else blank_attr = value;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    reset_screen_model();
    send_idle_pct = 30;
    recv_stall_pct = 47;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    queue_directed_ops();
    wait_for_quiet();
    set_attribute_register(CFG_TELETYPE_ATTR, 8'hFF);
    set_attribute_register(CFG_BLANK_ATTR, 8'h00);
    queue_random_phase(440);
    wait_for_quiet();

    send_idle_pct = 47;
    recv_stall_pct = 30;
    set_attribute_register(CFG_TELETYPE_ATTR, 8'h00);
    set_attribute_register(CFG_BLANK_ATTR, 8'hFF);
    queue_random_phase(440);
    wait_for_quiet();

    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_attribute_register(CFG_TELETYPE_ATTR, 8'($urandom_range(255)));
    set_attribute_register(CFG_BLANK_ATTR, 8'($urandom_range(255)));
    queue_random_phase(440);
    wait_for_quiet();
    repeat (20) @(posedge clk);

    $display("tb: %0d transactions checked, %0d reads, %0d clears, four attribute settings",
             results_checked, read_count, clear_count);
    $display("tb: %0d scrolls and %0d line wraps predicted, %0d mismatches",
             scroll_count, wrap_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
